>>> design/fixed_point_calculator_alu_core_assert.svh
// assertion helpers shared by the calculator modules
`ifndef FIXED_POINT_CALCULATOR_ALU_CORE_ASSERT_SVH
`define FIXED_POINT_CALCULATOR_ALU_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define FPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define FPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/fpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpc_pkg;

  // operation codes
  localparam logic [3:0] FN_ADD   = 4'd1;
  localparam logic [3:0] FN_SUB   = 4'd2;
  localparam logic [3:0] FN_MUL   = 4'd3;
  localparam logic [3:0] FN_DIV   = 4'd4;
  localparam logic [3:0] FN_SQR   = 4'd5;
  localparam logic [3:0] FN_SQRT  = 4'd6;
  localparam logic [3:0] FN_PRIME = 4'd7;
  localparam logic [3:0] FN_FACT  = 4'd8;

  // status codes
  localparam int STW = 3;
  localparam logic [STW-1:0] ST_OK      = 3'd0;
  localparam logic [STW-1:0] ST_DIV0    = 3'd1;
  localparam logic [STW-1:0] ST_NEGSQRT = 3'd2;
  localparam logic [STW-1:0] ST_FACTDOM = 3'd3;
  localparam logic [STW-1:0] ST_OVF     = 3'd4;
  localparam logic [STW-1:0] ST_BADOP   = 3'd5;

  // factorial index width, overflow always hits well before it wraps
  localparam int FACT_IW = 6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_MUL,
    S_DIV,
    S_SQRT,
    S_PCHK,
    S_PDIV,
    S_PTEST,
    S_FACT,
    S_PACK,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    CLS_QUICK,
    CLS_MUL,
    CLS_DIV,
    CLS_SQRT,
    CLS_PRIME,
    CLS_FACT
  } cls_t;

  typedef struct packed {
    logic start;
    logic init;
    logic mul_step;
    logic div_step;
    logic sqrt_step;
    logic fact_step;
    logic trial_load;
    logic trial_next;
    logic pack;
    logic set_prime;
    logic set_notprime;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic psq_gt;
    logic rem_zero;
    logic fact_end;
  } sts_t;

endpackage

`default_nettype wire

>>> design/fpc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module fpc_dpath #(
  parameter int INT_BITS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire fpc_pkg::cmd_t                       cmd,
  output fpc_pkg::sts_t                            sts,
  input  wire logic [3:0]                          in_func,
  input  wire logic signed [INT_BITS+FRAC_BITS-1:0] in_operand_a,
  input  wire logic signed [INT_BITS+FRAC_BITS-1:0] in_operand_b,
  output logic signed [INT_BITS+FRAC_BITS-1:0]     out_result,
  output logic [fpc_pkg::STW-1:0]                  out_status
);

  localparam int W   = INT_BITS + FRAC_BITS;
  localparam int NW  = W + FRAC_BITS;
  localparam int K   = (NW + 1) / 2;
  localparam int RW  = 2 * K;
  localparam int SW  = K + 4;
  localparam int PW  = 2 * W;
  localparam int FW  = fpc_pkg::FACT_IW;
  localparam int FPW = INT_BITS + FW;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] FMASK = (W'(1) << FRAC_BITS) - W'(1);
  localparam logic [W-1:0] ONEV = W'(1) << FRAC_BITS;
  localparam logic [INT_BITS-1:0] LIM = {1'b0, {(INT_BITS-1){1'b1}}};

  logic [3:0]          func_r;
  logic [W-1:0]        a_r, b_r;
  logic                neg_r;
  logic [W-1:0]        mhi_r, mlo_r, mb_r;
  logic [NW-1:0]       quo_r;
  logic [W-1:0]        rem_r, d_r;
  logic [RW-1:0]       rad_r;
  logic [K-1:0]        root_r;
  logic [SW-1:0]       srem_r;
  logic [INT_BITS-1:0] pi_r;
  logic [INT_BITS:0]   psq_r;
  logic [INT_BITS-1:0] fp_r;
  logic [FW-1:0]       fi_r;
  logic [W-1:0]        res_r, out_res_r;
  logic [fpc_pkg::STW-1:0] st_r, out_st_r;

  logic [W-1:0]        ma, mb;
  logic [INT_BITS-1:0] n_w;
  fpc_pkg::cls_t       cls;
  logic [W-1:0]        q_res;
  logic [fpc_pkg::STW-1:0] q_st;
  logic [W:0]          sum_w;

  // operand magnitudes and integer part
  assign ma  = a_r[W-1] ? (~a_r + W'(1)) : a_r;
  assign mb  = b_r[W-1] ? (~b_r + W'(1)) : b_r;
  assign n_w = a_r[W-1:FRAC_BITS];

  // classify the latched request
  always_comb begin
    case (func_r)
      fpc_pkg::FN_MUL, fpc_pkg::FN_SQR: cls = fpc_pkg::CLS_MUL;
      fpc_pkg::FN_DIV: cls = (b_r == '0) ? fpc_pkg::CLS_QUICK : fpc_pkg::CLS_DIV;
      fpc_pkg::FN_SQRT: cls = a_r[W-1] ? fpc_pkg::CLS_QUICK : fpc_pkg::CLS_SQRT;
      fpc_pkg::FN_PRIME: begin
        cls = (a_r[W-1] || n_w <= INT_BITS'(1)) ? fpc_pkg::CLS_QUICK : fpc_pkg::CLS_PRIME;
      end
      fpc_pkg::FN_FACT: begin
        cls = (a_r[W-1] || (a_r & FMASK) != '0) ? fpc_pkg::CLS_QUICK : fpc_pkg::CLS_FACT;
      end
      default: cls = fpc_pkg::CLS_QUICK;
    endcase
  end

  // results without iteration: add, sub, errors, trivial prime
  always_comb begin
    q_res = '0;
    q_st  = fpc_pkg::ST_OK;
    sum_w = '0;
    case (func_r)
      fpc_pkg::FN_ADD, fpc_pkg::FN_SUB: begin
        if (func_r == fpc_pkg::FN_ADD) begin
          sum_w = {a_r[W-1], a_r} + {b_r[W-1], b_r};
        end else begin
          sum_w = {a_r[W-1], a_r} - {b_r[W-1], b_r};
        end
        if (sum_w[W] != sum_w[W-1]) begin
          q_res = sum_w[W] ? MINV : MAXV;
          q_st  = fpc_pkg::ST_OVF;
        end else begin
          q_res = sum_w[W-1:0];
        end
      end
      fpc_pkg::FN_DIV:   q_st = fpc_pkg::ST_DIV0;
      fpc_pkg::FN_SQRT:  q_st = fpc_pkg::ST_NEGSQRT;
      fpc_pkg::FN_FACT:  q_st = fpc_pkg::ST_FACTDOM;
      fpc_pkg::FN_PRIME: q_st = fpc_pkg::ST_OK;
      default:           q_st = fpc_pkg::ST_BADOP;
    endcase
  end

  // restoring divide step
  logic [W:0]   dv_r1;
  logic         dv_ge;
  logic [W:0]   dv_diff;
  assign dv_r1   = {rem_r, quo_r[NW-1]};
  assign dv_ge   = dv_r1 >= {1'b0, d_r};
  assign dv_diff = dv_r1 - {1'b0, d_r};

  // shift-add multiply step
  logic [W:0] ml_sum;
  assign ml_sum = {1'b0, mhi_r} + (mlo_r[0] ? {1'b0, mb_r} : '0);

  // digit-by-digit root step
  logic [SW-1:0] sq_rem, sq_trial;
  logic          sq_ge;
  assign sq_rem   = {srem_r[SW-3:0], rad_r[RW-1 -: 2]};
  assign sq_trial = SW'({root_r, 2'b01});
  assign sq_ge    = sq_rem >= sq_trial;

  // factorial step
  logic [FPW-1:0] f_prod;
  logic           f_gt, f_ovf;
  assign f_prod = FPW'(fp_r) * FPW'(fi_r);
  assign f_gt   = INT_BITS'(fi_r) > n_w;
  assign f_ovf  = f_prod > FPW'(LIM);

  // saturating pack of a magnitude
  logic [PW-1:0] pk_v;
  logic [W-1:0]  pk_res;
  logic          pk_ovf;
  always_comb begin
    case (func_r)
      fpc_pkg::FN_MUL, fpc_pkg::FN_SQR: pk_v = {mhi_r, mlo_r} >> FRAC_BITS;
      fpc_pkg::FN_DIV: pk_v = PW'(quo_r);
      default:         pk_v = PW'(root_r);
    endcase
    if (neg_r) begin
      pk_ovf = pk_v > PW'(MINV);
      pk_res = pk_ovf ? MINV : (~pk_v[W-1:0] + W'(1));
    end else begin
      pk_ovf = pk_v > PW'(MAXV);
      pk_res = pk_ovf ? MAXV : pk_v[W-1:0];
    end
  end

  // status toward the controller
  always_comb begin
    sts.cls      = cls;
    sts.psq_gt   = psq_r > {1'b0, n_w};
    sts.rem_zero = rem_r == '0;
    sts.fact_end = f_gt || f_ovf;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func_r <= in_func;
      a_r    <= in_operand_a;
      b_r    <= in_operand_b;
    end
    if (cmd.init) begin
      res_r  <= q_res;
      st_r   <= q_st;
      neg_r  <= (func_r == fpc_pkg::FN_MUL || func_r == fpc_pkg::FN_DIV) ?
                (a_r[W-1] ^ b_r[W-1]) : 1'b0;
      mhi_r  <= '0;
      mlo_r  <= ma;
      mb_r   <= (func_r == fpc_pkg::FN_SQR) ? ma : mb;
      quo_r  <= NW'(ma) << FRAC_BITS;
      rem_r  <= '0;
      d_r    <= mb;
      rad_r  <= RW'(a_r) << FRAC_BITS;
      root_r <= '0;
      srem_r <= '0;
      pi_r   <= INT_BITS'(2);
      psq_r  <= (INT_BITS+1)'(4);
      fp_r   <= INT_BITS'(1);
      fi_r   <= FW'(2);
    end
    if (cmd.mul_step) begin
      mhi_r <= ml_sum[W:1];
      mlo_r <= {ml_sum[0], mlo_r[W-1:1]};
    end
    if (cmd.div_step) begin
      rem_r <= dv_ge ? dv_diff[W-1:0] : dv_r1[W-1:0];
      quo_r <= {quo_r[NW-2:0], dv_ge};
    end
    if (cmd.sqrt_step) begin
      srem_r <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
      root_r <= {root_r[K-2:0], sq_ge};
      rad_r  <= rad_r << 2;
    end
    if (cmd.trial_load) begin
      quo_r <= NW'(n_w);
      rem_r <= '0;
      d_r   <= W'(pi_r);
    end
    if (cmd.trial_next) begin
      psq_r <= psq_r + {pi_r, 1'b1};
      pi_r  <= pi_r + INT_BITS'(1);
    end
    if (cmd.fact_step) begin
      if (f_gt) begin
        res_r <= W'(fp_r) << FRAC_BITS;
        st_r  <= fpc_pkg::ST_OK;
      end else if (f_ovf) begin
        res_r <= MAXV;
        st_r  <= fpc_pkg::ST_OVF;
      end else begin
        fp_r <= f_prod[INT_BITS-1:0];
        fi_r <= fi_r + FW'(1);
      end
    end
    if (cmd.pack) begin
      res_r <= pk_res;
      st_r  <= pk_ovf ? fpc_pkg::ST_OVF : fpc_pkg::ST_OK;
    end
    if (cmd.set_prime) begin
      res_r <= ONEV;
      st_r  <= fpc_pkg::ST_OK;
    end
    if (cmd.set_notprime) begin
      res_r <= '0;
      st_r  <= fpc_pkg::ST_OK;
    end
    if (cmd.load_out) begin
      out_res_r <= res_r;
      out_st_r  <= st_r;
    end
  end

  assign out_result = out_res_r;
  assign out_status = out_st_r;

`include "fixed_point_calculator_alu_core_assert.svh"

  `FPC_ASSERT_NXT(a_pack_status, cmd.pack, st_r == fpc_pkg::ST_OK || st_r == fpc_pkg::ST_OVF, "pack gave an error status")

endmodule

`default_nettype wire

>>> design/fpc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fpc_ctrl #(
  parameter int INT_BITS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output fpc_pkg::cmd_t      cmd,
  input  wire fpc_pkg::sts_t sts
);

  localparam int W  = INT_BITS + FRAC_BITS;
  localparam int NW = W + FRAC_BITS;
  localparam int K  = (NW + 1) / 2;
  localparam int CW = $clog2(NW + 1);

  fpc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fpc_pkg::S_IDLE: if (in_valid) state_nxt = fpc_pkg::S_INIT;
      fpc_pkg::S_INIT: begin
        case (sts.cls)
          fpc_pkg::CLS_MUL:   state_nxt = fpc_pkg::S_MUL;
          fpc_pkg::CLS_DIV:   state_nxt = fpc_pkg::S_DIV;
          fpc_pkg::CLS_SQRT:  state_nxt = fpc_pkg::S_SQRT;
          fpc_pkg::CLS_PRIME: state_nxt = fpc_pkg::S_PCHK;
          fpc_pkg::CLS_FACT:  state_nxt = fpc_pkg::S_FACT;
          default:            state_nxt = fpc_pkg::S_OUT;
        endcase
      end
      fpc_pkg::S_MUL:  if (cnt_r == CW'(W - 1)) state_nxt = fpc_pkg::S_PACK;
      fpc_pkg::S_DIV:  if (cnt_r == CW'(NW - 1)) state_nxt = fpc_pkg::S_PACK;
      fpc_pkg::S_SQRT: if (cnt_r == CW'(K - 1)) state_nxt = fpc_pkg::S_PACK;
      fpc_pkg::S_PCHK: state_nxt = sts.psq_gt ? fpc_pkg::S_OUT : fpc_pkg::S_PDIV;
      fpc_pkg::S_PDIV: if (cnt_r == CW'(NW - 1)) state_nxt = fpc_pkg::S_PTEST;
      fpc_pkg::S_PTEST: state_nxt = sts.rem_zero ? fpc_pkg::S_OUT : fpc_pkg::S_PCHK;
      fpc_pkg::S_FACT: if (sts.fact_end) state_nxt = fpc_pkg::S_OUT;
      fpc_pkg::S_PACK: state_nxt = fpc_pkg::S_OUT;
      fpc_pkg::S_OUT:  if (slot_free) state_nxt = fpc_pkg::S_IDLE;
      default:         state_nxt = fpc_pkg::S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd = '0;
    case (state_r)
      fpc_pkg::S_IDLE:  cmd.start = in_valid;
      fpc_pkg::S_INIT:  cmd.init = 1'b1;
      fpc_pkg::S_MUL:   cmd.mul_step = 1'b1;
      fpc_pkg::S_DIV:   cmd.div_step = 1'b1;
      fpc_pkg::S_SQRT:  cmd.sqrt_step = 1'b1;
      fpc_pkg::S_PCHK: begin
        cmd.set_prime  = sts.psq_gt;
        cmd.trial_load = !sts.psq_gt;
      end
      fpc_pkg::S_PDIV:  cmd.div_step = 1'b1;
      fpc_pkg::S_PTEST: begin
        cmd.set_notprime = sts.rem_zero;
        cmd.trial_next   = !sts.rem_zero;
      end
      fpc_pkg::S_FACT:  cmd.fact_step = 1'b1;
      fpc_pkg::S_PACK:  cmd.pack = 1'b1;
      fpc_pkg::S_OUT:   cmd.load_out = slot_free;
      default:          cmd = '0;
    endcase
  end

  // iteration counter restarts on every state change
  assign cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + CW'(1);

  // result slot occupancy
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpc_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != fpc_pkg::S_IDLE;
  assign out_valid = out_valid_r;

`include "fixed_point_calculator_alu_core_assert.svh"

  `FPC_ASSERT_NXT(a_accept_init, in_valid && !in_stall, state_r == fpc_pkg::S_INIT, "accepted request did not start")
  `FPC_ASSERT_IMP(a_load_free, cmd.load_out, !out_valid_r || !out_stall, "result overwrote a pending one")
  `FPC_ASSERT_IMP(a_cnt_bound, state_r == fpc_pkg::S_DIV || state_r == fpc_pkg::S_PDIV, cnt_r < CW'(NW), "divide counter ran past its end")

endmodule

`default_nettype wire

>>> design/fixed_point_calculator_alu_core.sv
// fixed-point calculator alu
// input channel: in_valid / in_stall carry a request of in_func, in_operand_a and
// in_operand_b (signed, FRAC_BITS fraction bits); a request is taken when in_valid
// is high and in_stall low. one request is worked on at a time; in_stall is high
// from the cycle after a request is taken until its result is in the output register.
// result channel: out_valid / out_stall carry out_result and out_status; the result
// holds in the output register while out_stall is high, and a new request may be
// taken while it waits there.
// how each operation is worked out once a request is taken:
//   add, sub, errors, trivial prime: formed at init, no iteration
//   mul, square: one bit per cycle of the shift-add multiplier
//   div: one quotient bit per cycle of the restoring divider
//   sqrt: one root bit per cycle
//   factorial: one product per cycle
//   prime: trial divisors from 2 up to about sqrt(n); each trial divisor runs
//     a full pass of the shared divider
// reset clears the controller and drops out_valid; no memory to clear
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_calculator_alu_core #(
  parameter int INT_BITS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [3:0]                           in_func,
  input  wire logic signed [INT_BITS+FRAC_BITS-1:0] in_operand_a,
  input  wire logic signed [INT_BITS+FRAC_BITS-1:0] in_operand_b,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [INT_BITS+FRAC_BITS-1:0]      out_result,
  output logic [fpc_pkg::STW-1:0]                   out_status
);

  fpc_pkg::cmd_t cmd;
  fpc_pkg::sts_t sts;

  // sequencer
  fpc_ctrl #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // arithmetic
  fpc_dpath #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_func      (in_func),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_result   (out_result),
    .out_status   (out_status)
  );

endmodule

`default_nettype wire
